// ===== rtl/sprite_frame_mirror_select_top_macros.svh =====
// assertion helpers for the sprite frame mirror select block
// each macro expects clk in scope; SFMS_ASSERT also expects rst_n
`ifndef SPRITE_FRAME_MIRROR_SELECT_TOP_MACROS_SVH
`define SPRITE_FRAME_MIRROR_SELECT_TOP_MACROS_SVH
`ifndef SYNTH
// checked outside reset
`define SFMS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sfms assertion failed");
// checked at every edge, reset included
`define SFMS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sfms reset assertion failed");
`else
`define SFMS_ASSERT(lbl, prop)
`define SFMS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== rtl/sfms_pkg.sv =====
`default_nettype none
package sfms_pkg;

  // register map, word index from paddr[3:2]
  typedef enum logic [1:0] {
    REG_FRAMES_PER_DIR = 2'd0,
    REG_DIR_COUNT      = 2'd1,
    REG_MIRROR_MODE    = 2'd2,
    REG_STORED_TOTAL   = 2'd3
  } reg_idx_t;

  localparam int unsigned PADDR_W = 4;
  localparam logic [8:0] TWO_ANGLES = 9'd2;

  // sprite layout as held in the register file
  typedef struct packed {
    logic [7:0]  frames_per_direction;
    logic [8:0]  direction_count;
    logic [7:0]  mirror_mode;
    logic [15:0] stored_frame_total;
  } cfg_t;

  // one lookup result
  typedef struct packed {
    logic        valid_res;
    logic [15:0] frame_number;
    logic        mirror_flag;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/sfms_regs.sv =====
`default_nettype none
module sfms_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfms_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output sfms_pkg::cfg_t               cfg
);
  import sfms_pkg::*;

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_FRAMES_PER_DIR: cfg_nxt.frames_per_direction = pwdata[7:0];
        REG_DIR_COUNT:      cfg_nxt.direction_count      = pwdata[8:0];
        REG_MIRROR_MODE:    cfg_nxt.mirror_mode          = pwdata[7:0];
        REG_STORED_TOTAL:   cfg_nxt.stored_frame_total   = pwdata[15:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_FRAMES_PER_DIR: prdata = {24'd0, cfg_r.frames_per_direction};
      REG_DIR_COUNT:      prdata = {23'd0, cfg_r.direction_count};
      REG_MIRROR_MODE:    prdata = {24'd0, cfg_r.mirror_mode};
      REG_STORED_TOTAL:   prdata = {16'd0, cfg_r.stored_frame_total};
      default:            prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/sfms_calc.sv =====
`default_nettype none
module sfms_calc (
  input  sfms_pkg::cfg_t cfg,
  input  logic [7:0]     facing_angle,
  input  logic [7:0]     step_in_action,
  output sfms_pkg::res_t res
);
  import sfms_pkg::*;

  logic [7:0]         fpd;
  logic [8:0]         cnt;
  logic [7:0]         mm;
  logic [6:0]         quarter;
  logic [7:0]         half;
  logic               mirrored;
  logic               two_angle;
  logic               mm_in_range;
  logic [8:0]         span;
  logic [16:0]        expected;
  logic               outside;
  logic signed [10:0] a_s;
  logic signed [10:0] c_s;
  logic signed [10:0] h_s;
  logic signed [10:0] q_s;
  logic signed [10:0] refl_s;
  logic signed [10:0] stored_s;
  logic [17:0]        prod;
  logic [18:0]        frame;

  assign fpd       = cfg.frames_per_direction;
  assign cnt       = cfg.direction_count;
  assign mm        = cfg.mirror_mode;
  assign quarter   = cnt[8:2];
  assign half      = cnt[8:1];
  assign mirrored  = (mm != 8'd0);
  assign two_angle = (cnt == TWO_ANGLES);
  assign mm_in_range = (mm >= {1'b0, quarter}) && ({1'b0, mm} < cnt);

  // angle count that the stored total must cover
  always_comb begin
    if (!mirrored) begin
      span = cnt;
    end else if (two_angle) begin
      span = 9'd1;
    end else if (mm_in_range) begin
      span = {1'b0, mm} - {2'b00, quarter} + 9'd1;
    end else begin
      span = 9'd0;
    end
  end

  assign expected = 17'(fpd) * 17'(span);

  // stored angle, mirrored about the quarter turn outside the stored range
  assign a_s     = signed'({3'b000, facing_angle});
  assign c_s     = signed'({2'b00, cnt});
  assign h_s     = signed'({3'b000, half});
  assign q_s     = signed'({4'b0000, quarter});
  assign outside = (facing_angle > mm) || (facing_angle < {1'b0, quarter});
  assign refl_s  = ((facing_angle > half) ? (h_s - a_s + c_s) : (h_s - a_s)) - q_s;

  always_comb begin
    if (!mirrored) begin
      stored_s = a_s;
    end else if (outside) begin
      stored_s = refl_s;
    end else begin
      stored_s = a_s - q_s;
    end
  end

  assign prod  = 18'(stored_s[9:0]) * 18'(fpd);
  assign frame = 19'(prod) + 19'(step_in_action);

  // checks in priority order
  always_comb begin
    res = '0;
    if (fpd == 8'd0 || cnt == 9'd0 || step_in_action >= fpd) begin
      res = '0;
    end else if (expected != 17'(cfg.stored_frame_total)) begin
      res = '0;
    end else if (mirrored && two_angle) begin
      res.valid_res    = 1'b1;
      res.frame_number = 16'(step_in_action);
      res.mirror_flag  = (facing_angle != 8'd0);
    end else if ({1'b0, facing_angle} >= cnt) begin
      res = '0;
    end else if (stored_s[10]) begin
      res = '0;
    end else if (frame >= 19'(cfg.stored_frame_total)) begin
      res = '0;
    end else begin
      res.valid_res    = 1'b1;
      res.frame_number = frame[15:0];
      res.mirror_flag  = mirrored && outside;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sprite_frame_mirror_select_top.sv =====
// sprite frame mirror select
// a word accepted is held in the input register, then its result in the result register that drives the outputs
// throughput: one word per cycle while out_ready is high, set by the input register and result register pair
// two words in flight at most; while a result waits the input takes one more word, then stalls
// reset: synchronous active-low rst_n clears both stage valids and all config registers
`default_nettype none
`include "sprite_frame_mirror_select_top_macros.svh"
module sprite_frame_mirror_select_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_facing_angle,
  input  logic [7:0]  in_step_in_action,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_valid_res,
  output logic [15:0] out_frame_number,
  output logic        out_mirror_flag,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import sfms_pkg::*;

  cfg_t       cfg;
  res_t       calc_res;
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  logic [7:0] angle_r;
  logic [7:0] step_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  res_t       res_r;
  logic       s2_load;

  sfms_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  sfms_calc u_calc (
    .cfg            (cfg),
    .facing_angle   (angle_r),
    .step_in_action (step_r),
    .res            (calc_res)
  );

  // stage handshake
  assign s2_load  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s2_load;

  always_comb begin
    s1_valid_nxt  = in_ready ? in_valid : s1_valid_r;
    out_valid_nxt = (!out_valid_r || out_ready) ? s1_valid_r : out_valid_r;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      angle_r <= in_facing_angle;
      step_r  <= in_step_in_action;
    end
    if (s2_load) begin
      res_r <= calc_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_valid_res    = res_r.valid_res;
  assign out_frame_number = res_r.frame_number;
  assign out_mirror_flag  = res_r.mirror_flag;

  // checks
  `SFMS_ASSERT(a_invalid_zero,
    out_valid_r && !res_r.valid_res |-> res_r.frame_number == 16'd0 && !res_r.mirror_flag)
  `SFMS_ASSERT(a_stall_blocks, s1_valid_r && out_valid_r && !out_ready |-> !in_ready)
  `SFMS_ASSERT(a_s1_moves, s1_valid_r && !out_valid_r |=> out_valid_r)
  `SFMS_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> !out_valid_r && !s1_valid_r)

endmodule
`default_nettype wire
